>>> hw/rtl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants for the seven-segment scan serializer
// Holds field widths, the segment table and the word passed through the queue.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int VALUE_W         = 16;  // display value width
  localparam int BCD_DIGITS      = 5;   // decimal digits of a 16-bit value
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int BYTE_W          = 8;   // bits per shifted byte
  localparam int WORD_W          = 2 * BYTE_W;
  localparam int DEF_DIGIT_COUNT = 4;
  localparam int QUEUE_DEPTH     = 2;

  // One scan word: segment byte goes out first, then the digit-select byte.
  typedef struct packed {
    logic [BYTE_W-1:0] seg;
    logic [BYTE_W-1:0] sel;
  } word_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

  // Common-anode patterns: a 0 bit lights a segment.
  function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] digit);
    logic [BYTE_W-1:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'hC0;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/seven_segment_scan_serializer_core.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_serializer_core: multiplexed display shift-register driver
// Turns each display value into one digit's serial bit run for a pair of
// shift registers, rotating through the digit positions.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the slave stream is one scan tick carrying the value to
//   show. The block picks the current digit position, converts the value to
//   decimal and looks up that digit's common-anode segment byte. The master
//   stream then carries seventeen transfers: sixteen bit items (segment byte,
//   then one-hot digit-select byte, most significant bit first) with the
//   shift flag set, and one latch item with the latch flag and tlast set.
//   The position advances by one per tick and wraps at DIGIT_COUNT.
//
//   The decimal conversion runs one bit per cycle. The finished word goes
//   into the queue, and the first bit item then leaves through the output
//   register. The serializer sends 17 items per word, then loads the next
//   word from the queue. The conversion of the next tick overlaps the
//   serializing of this one.
//
//   Reset clears the digit position to zero and empties the queue. When the
//   receiver stalls, the current output transfer holds; up to two converted
//   words wait in the queue, after which the slave side stops accepting.
// ----------------------------------------------------------------------------
module seven_segment_scan_serializer_core import sss_pkg::*; #(
  parameter int DIGIT_COUNT = DEF_DIGIT_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // [15:0] display_value
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [BYTE_W-1:0]  m_tdata,   // [0] serial_data, [7:1] zero
  output logic [1:0]         m_tuser,   // [0] shift_strobe, [1] latch_strobe
  output logic               m_tlast    // last: latch item ending the run
);

  qstat_t qstat;
  logic   push;
  logic   pop;
  word_t  push_word;
  word_t  pop_word;

  // Front end: accepts the value and builds the segment and select bytes.
  sss_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .qstat    (qstat),
    .push     (push),
    .push_word(push_word)
  );

  // The queue lets the conversion run ahead while the output is stalled.
  sss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_word(push_word),
    .pop      (pop),
    .pop_word (pop_word),
    .qstat    (qstat)
  );

  // Back end: serializes each word through a registered output stage.
  sss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .pop_word(pop_word),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // Every output item is either a bit item or the latch item, never both.
  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tuser))
    else $error("output item carries no strobe or both strobes");

  // The run ends exactly on the latch item, whose data line is held low.
  a_last_is_latch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tlast == m_tuser[1]) && (!m_tuser[1] || (m_tdata == '0))))
    else $error("tlast does not match the latch item or latch data is set");

  // The front never writes a word into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!qstat.full || pop))
    else $error("scan word pushed into a full queue");

endmodule

>>> hw/rtl/sss_front.sv
// ----------------------------------------------------------------------------
// sss_front: input side of the scan serializer
// Converts the value to decimal one bit per cycle and builds the scan word.
// ----------------------------------------------------------------------------
module sss_front import sss_pkg::*; #(
  parameter int DIGIT_COUNT = DEF_DIGIT_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,
  input  qstat_t             qstat,
  output logic               push,
  output word_t              push_word
);

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int CNT_W = $clog2(VALUE_W + 1);
  localparam logic [CNT_W-1:0] STEPS   = CNT_W'(VALUE_W);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(DIGIT_COUNT - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [POS_W-1:0]   pos;

  logic               done;
  logic               accept;
  logic [BCD_W-1:0]   adj;
  logic [3:0]         digit;
  logic [2:0]         pos3;

  // Shift-and-add-3: correct every digit that would overflow when doubled.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Positions past the last decimal digit of a 16-bit value show zero.
  always_comb begin
    pos3  = 3'(pos);
    digit = 4'd0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (pos3 == 3'(i)) begin
        digit = bcd[4*i +: 4];
      end
    end
  end

  assign done          = busy && (cnt == STEPS);
  assign push          = done && !qstat.full;
  assign s_tready      = !busy || push;
  assign accept        = s_tvalid && s_tready;
  assign push_word.seg = seg_code(digit);
  assign push_word.sel = {{(BYTE_W-1){1'b0}}, 1'b1} << pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else begin
      if (push) begin
        pos <= (pos == POS_MAX) ? '0 : pos + POS_W'(1);
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (push) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= s_tdata;
      bcd <= '0;
      cnt <= '0;
    end else if (busy && !done) begin
      bcd <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

>>> hw/rtl/sss_queue.sv
// ----------------------------------------------------------------------------
// sss_queue: short word queue between the front and the back
// Two-entry first-in first-out buffer of scan words.
// ----------------------------------------------------------------------------
module sss_queue import sss_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  word_t  push_word,
  input  logic   pop,
  output word_t  pop_word,
  output qstat_t qstat
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  word_t         entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign qstat.not_empty = (count != '0);
  assign qstat.full      = (count == CW'(QUEUE_DEPTH));
  assign pop_word        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

>>> hw/rtl/sss_back.sv
// ----------------------------------------------------------------------------
// sss_back: output side of the scan serializer
// Shifts each scan word out one bit per transfer, then sends the latch item.
// ----------------------------------------------------------------------------
module sss_back import sss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  qstat_t            qstat,
  input  word_t             pop_word,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  localparam int CNT_W = $clog2(WORD_W + 1);
  localparam logic [CNT_W-1:0] LATCH_IDX = CNT_W'(WORD_W);

  logic              active;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] sh;
  logic              out_free;
  logic              serial;
  logic              shift_flag;
  logic              latch_flag;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = !active && qstat.not_empty;
  assign m_tdata  = {{(BYTE_W-1){1'b0}}, serial};
  assign m_tuser  = {latch_flag, shift_flag};

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (active && out_free) begin
        m_tvalid <= 1'b1;
        if (cnt == LATCH_IDX) begin
          active <= 1'b0;
        end
      end else if (out_free) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sh  <= pop_word;
      cnt <= '0;
    end else if (active && out_free) begin
      if (cnt == LATCH_IDX) begin
        serial     <= 1'b0;
        shift_flag <= 1'b0;
        latch_flag <= 1'b1;
        m_tlast    <= 1'b1;
      end else begin
        serial     <= sh[WORD_W-1];
        shift_flag <= 1'b1;
        latch_flag <= 1'b0;
        m_tlast    <= 1'b0;
        sh         <= {sh[WORD_W-2:0], 1'b0};
        cnt        <= cnt + CNT_W'(1);
      end
    end
  end

endmodule
